>>> hw/rtl/rptd_pkg.sv
`default_nettype none

package rptd_pkg;

  localparam int unsigned PALETTE_DEPTH_DEF = 256;
  localparam int unsigned TILE_PIXELS_DEF   = 256;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_COUNT      = 1'd1;

  localparam logic [1:0] OP_PAL_WRITE = 2'd0;
  localparam logic [1:0] OP_DATA      = 2'd1;
  localparam logic [1:0] OP_NEW_IMAGE = 2'd2;

  localparam logic [7:0] ESCAPE_BYTE = 8'd255;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  localparam int unsigned RGB_W = 18;

  typedef enum logic [1:0] {
    PH_LITERAL = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_INDEX   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic [7:0] palette_slot;
    logic [5:0] palette_red_in;
    logic [5:0] palette_green_in;
    logic [5:0] palette_blue_in;
  } in_item_t;

  typedef struct packed {
    logic             en;
    logic [7:0]       slot;
    logic [RGB_W-1:0] rgb;
  } pal_wr_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  index;
    logic        oob;
    logic [7:0]  count;
    logic [15:0] tile;
    logic [7:0]  offset;
    logic        done;
  } run_t;

endpackage

`default_nettype wire

>>> hw/rtl/rptd_if.sv
`default_nettype none

interface rptd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic [7:0] palette_slot;
  logic [5:0] palette_red_in;
  logic [5:0] palette_green_in;
  logic [5:0] palette_blue_in;

  modport source (
    output valid, opcode, data_byte, palette_slot,
           palette_red_in, palette_green_in, palette_blue_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, data_byte, palette_slot,
           palette_red_in, palette_green_in, palette_blue_in,
    output ready
  );
  modport monitor (
    input valid, ready, opcode, data_byte, palette_slot,
          palette_red_in, palette_green_in, palette_blue_in
  );
endinterface

interface rptd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_red;
  logic [7:0]  pixel_green;
  logic [7:0]  pixel_blue;
  logic [7:0]  pixel_alpha;
  logic [7:0]  repeat_count;
  logic [15:0] tile_number;
  logic [7:0]  pixel_in_tile;
  logic        image_done;

  modport source (
    output valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
           repeat_count, tile_number, pixel_in_tile, image_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
           repeat_count, tile_number, pixel_in_tile, image_done,
    output ready
  );
  modport monitor (
    input valid, ready, pixel_red, pixel_green, pixel_blue, pixel_alpha,
          repeat_count, tile_number, pixel_in_tile, image_done
  );
endinterface

`default_nettype wire

>>> hw/rtl/rptd_palette_mem.sv
`default_nettype none

module rptd_palette_mem #(
  parameter int unsigned DEPTH = rptd_pkg::PALETTE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [rptd_pkg::RGB_W-1:0] wdata,
  input  wire logic                       re,
  input  wire logic [AW-1:0]              raddr,
  output logic      [rptd_pkg::RGB_W-1:0] rdata
);
  import rptd_pkg::*;

  logic [RGB_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rptd_parser.sv
`default_nettype none

module rptd_parser #(
  parameter int unsigned PALETTE_DEPTH = rptd_pkg::PALETTE_DEPTH_DEF,
  parameter int unsigned TILE_PIXELS   = rptd_pkg::TILE_PIXELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [rptd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [rptd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            acc,
  input  wire rptd_pkg::in_item_t              item,
  output rptd_pkg::pal_wr_t                    pal_wr,
  output rptd_pkg::run_t                       run
);
  import rptd_pkg::*;

  localparam int unsigned OFF_W = $clog2(TILE_PIXELS);
  localparam int unsigned PD_W  = 16 + OFF_W;
  localparam int unsigned SUM_W = ((OFF_W > 8) ? OFF_W : 8) + 1;
  localparam int unsigned SH    = SUM_W + OFF_W + 1;
  localparam int unsigned RW    = SH - OFF_W + 2;
  localparam int unsigned PW    = SUM_W + RW;
  localparam int unsigned QW    = PW - SH;
  localparam int unsigned RECIP_I = ((1 << SH) + TILE_PIXELS - 1) / TILE_PIXELS;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_I);

  phase_t            phase_r, phase_nxt;
  logic [7:0]        pending_r, pending_nxt;
  logic [PD_W-1:0]   pixels_r, pixels_nxt;
  logic [PD_W-1:0]   total_r, total_nxt;
  logic [15:0]       tile_r, tile_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic              finished_r, finished_nxt;
  logic              compressed_r, compressed_nxt;

  logic              active;
  logic              emit_req;
  logic [7:0]        emit_idx;
  logic [7:0]        emit_len;
  logic [PD_W-1:0]   left;
  logic              done;
  logic [7:0]        count;
  logic [SUM_W-1:0]  sum;
  logic [PW-1:0]     prod;
  logic [QW-1:0]     quot;
  logic [SUM_W-1:0]  qt;
  logic [OFF_W+7:0]  off_ext;

  assign active   = !finished_r && (pixels_r < total_r);
  assign left     = total_r - pixels_r;
  assign done     = PD_W'(emit_len) >= left;
  assign count    = done ? left[7:0] : emit_len;
  assign sum      = SUM_W'(off_r) + SUM_W'(emit_len);
  assign prod     = PW'(sum) * PW'(RECIP);
  assign quot     = prod[PW-1:SH];
  assign qt       = SUM_W'(SUM_W'(quot) * SUM_W'(TILE_PIXELS));
  assign off_ext  = {8'd0, off_r};

  always_comb begin
    phase_nxt      = phase_r;
    pending_nxt    = pending_r;
    pixels_nxt     = pixels_r;
    total_nxt      = total_r;
    tile_nxt       = tile_r;
    off_nxt        = off_r;
    finished_nxt   = finished_r;
    compressed_nxt = compressed_r;
    emit_req       = 1'b0;
    emit_idx       = item.data_byte;
    emit_len       = 8'd1;
    pal_wr.en      = 1'b0;
    pal_wr.slot    = item.palette_slot;
    pal_wr.rgb     = {item.palette_red_in, item.palette_green_in, item.palette_blue_in};

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_COMPRESSED_MODE: compressed_nxt = cfg_wdata[0];
        CFG_TILE_COUNT:      total_nxt = PD_W'(PD_W'(cfg_wdata) * PD_W'(TILE_PIXELS));
        default: ;
      endcase
    end

    if (acc) begin
      unique case (item.opcode)
        OP_PAL_WRITE: begin
          pal_wr.en = {1'b0, item.palette_slot} < 9'(PALETTE_DEPTH);
        end
        OP_NEW_IMAGE: begin
          phase_nxt    = PH_LITERAL;
          pending_nxt  = 8'd0;
          pixels_nxt   = '0;
          tile_nxt     = 16'd0;
          off_nxt      = '0;
          finished_nxt = 1'b0;
        end
        OP_DATA: begin
          if (active) begin
            if (!compressed_r) begin
              phase_nxt = PH_LITERAL;
              emit_req  = 1'b1;
            end else begin
              unique case (phase_r)
                PH_LENGTH: begin
                  pending_nxt = item.data_byte;
                  phase_nxt   = PH_INDEX;
                end
                PH_INDEX: begin
                  phase_nxt = PH_LITERAL;
                  emit_len  = pending_r;
                  emit_req  = 1'b1;
                end
                default: begin
                  if (item.data_byte == ESCAPE_BYTE) begin
                    phase_nxt = PH_LENGTH;
                  end else begin
                    phase_nxt = PH_LITERAL;
                    emit_req  = 1'b1;
                  end
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    end

    run.valid  = emit_req && (emit_len != 8'd0);
    run.index  = emit_idx;
    run.oob    = {1'b0, emit_idx} >= 9'(PALETTE_DEPTH);
    run.count  = count;
    run.tile   = tile_r;
    run.offset = off_ext[7:0];
    run.done   = done;

    if (run.valid) begin
      pixels_nxt   = pixels_r + PD_W'(count);
      finished_nxt = done;
      tile_nxt     = tile_r + 16'(quot);
      off_nxt      = OFF_W'(sum - qt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LITERAL;
      pending_r    <= 8'd0;
      pixels_r     <= '0;
      total_r      <= PD_W'(TILE_PIXELS);
      tile_r       <= 16'd0;
      off_r        <= '0;
      finished_r   <= 1'b0;
      compressed_r <= 1'b1;
    end else begin
      phase_r      <= phase_nxt;
      pending_r    <= pending_nxt;
      pixels_r     <= pixels_nxt;
      total_r      <= total_nxt;
      tile_r       <= tile_nxt;
      off_r        <= off_nxt;
      finished_r   <= finished_nxt;
      compressed_r <= compressed_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rle_palette_tile_decoder_top.sv
// Escape-byte run-length decoder with a palette, for images of 16x16-style tiles. A new
// in_ch transaction may follow each accepted one in the next cycle while in_ch.ready is
// high; a run's result appears on out_ch in the cycle after the transaction that
// completes it, set by the registered read of the palette memory. in_ch is held off only
// while a result waits and out_ch.ready is low. Palette writes, start-of-image and
// escape/length bytes give no result. The palette is not cleared after reset: entries
// hold unknown colours until written. Write cfg_* only while no result is outstanding.
`default_nettype none

module rle_palette_tile_decoder_top #(
  parameter int unsigned PALETTE_DEPTH = rptd_pkg::PALETTE_DEPTH_DEF,
  parameter int unsigned TILE_PIXELS   = rptd_pkg::TILE_PIXELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  rptd_in_if.sink                              in_ch,
  rptd_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [rptd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [rptd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rptd_pkg::*;

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);

  in_item_t         item;
  pal_wr_t          pal_wr;
  run_t             run;
  logic             acc;
  logic             load;
  logic [RGB_W-1:0] rgb;

  logic             out_valid_r, out_valid_nxt;
  logic             zero_r;
  logic             oob_r;
  logic [7:0]       count_r;
  logic [15:0]      tile_r;
  logic [7:0]       offset_r;
  logic             done_r;

  assign item.opcode           = in_ch.opcode;
  assign item.data_byte        = in_ch.data_byte;
  assign item.palette_slot     = in_ch.palette_slot;
  assign item.palette_red_in   = in_ch.palette_red_in;
  assign item.palette_green_in = in_ch.palette_green_in;
  assign item.palette_blue_in  = in_ch.palette_blue_in;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign load        = run.valid;

  rptd_parser #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .TILE_PIXELS   (TILE_PIXELS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .item      (item),
    .pal_wr    (pal_wr),
    .run       (run)
  );

  rptd_palette_mem #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW)
  ) u_palette (
    .clk   (clk),
    .we    (pal_wr.en),
    .waddr (pal_wr.slot[AW-1:0]),
    .wdata (pal_wr.rgb),
    .re    (load),
    .raddr (run.index[AW-1:0]),
    .rdata (rgb)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold run details alongside the palette read data
  always_ff @(posedge clk) begin
    if (load) begin
      zero_r   <= run.index == 8'd0;
      oob_r    <= run.oob;
      count_r  <= run.count;
      tile_r   <= run.tile;
      offset_r <= run.offset;
      done_r   <= run.done;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_red     = (zero_r || oob_r) ? 8'd0 : {rgb[17:12], 2'b00};
  assign out_ch.pixel_green   = (zero_r || oob_r) ? 8'd0 : {rgb[11:6], 2'b00};
  assign out_ch.pixel_blue    = (zero_r || oob_r) ? 8'd0 : {rgb[5:0], 2'b00};
  assign out_ch.pixel_alpha   = zero_r ? 8'd0 : ALPHA_OPAQUE;
  assign out_ch.repeat_count  = count_r;
  assign out_ch.tile_number   = tile_r;
  assign out_ch.pixel_in_tile = offset_r;
  assign out_ch.image_done    = done_r;

endmodule

`default_nettype wire

>>> hw/rtl/rptd_checker.sv
`default_nettype none

module rptd_checker (
  input wire logic   clk,
  input wire logic   rst_n,
  rptd_in_if.sink    in_ch,
  rptd_out_if.source out_ch
);
  import rptd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.repeat_count)
      && $stable(out_ch.tile_number) && $stable(out_ch.pixel_red))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");

  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !($past(out_ch.valid) && !$past(out_ch.ready))
      |-> $past(in_ch.valid && in_ch.ready))
    else $error("new result without an input transaction");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.repeat_count != 8'd0)
    else $error("empty run delivered");

  a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.pixel_alpha == ALPHA_OPAQUE) ||
      (out_ch.pixel_alpha == 8'd0 && out_ch.pixel_red == 8'd0 &&
       out_ch.pixel_green == 8'd0 && out_ch.pixel_blue == 8'd0))
    else $error("transparent pixel carries colour");

endmodule

bind rle_palette_tile_decoder_top rptd_checker u_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

`default_nettype wire
